>>> rtl/ncs_pkg.sv
// Shared types, constants and register codes for the nearest candidate scan.
package ncs_pkg;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CAND  = 1'b1;

    // Configuration register indexes
    localparam logic REG_GATE_MASK      = 1'b0;
    localparam logic REG_THRESHOLD_HIGH = 1'b1;

    localparam logic [7:0] GATE_MASK_RESET      = 8'h80;
    localparam logic [7:0] THRESHOLD_HIGH_RESET = 8'hFF;

    // Candidate indexes at or above this are never eligible (range 1 to 256)
    localparam int CANDIDATES = 16;

    // Default queue depths
    localparam int QUEUE_DEPTH  = 4;
    localparam int RESULT_DEPTH = 2;

    typedef struct packed {
        logic        kind;
        logic [15:0] pos_x;
        logic [7:0]  pos_depth;
        logic [3:0]  item_index;
        logic [7:0]  gate_bits;
        logic        last;
        logic [15:0] prior_metric;
        logic [7:0]  prior_best;
        logic [7:0]  prior_threshold_low;
        logic [7:0]  prior_marker;
        logic [3:0]  slot_number;
    } ncs_in_t;

    typedef struct packed {
        logic [15:0] last_metric;
        logic [15:0] best_metric;
        logic [7:0]  best_index;
        logic [7:0]  best_marker;
        logic        improved;
        logic [3:0]  slot_out;
    } ncs_out_t;

    // Classified operation handed from the front to the back
    typedef struct packed {
        logic        kind;
        logic        eligible;
        logic        last;
        logic [15:0] pos_x;
        logic [7:0]  pos_depth;
        logic [3:0]  item_index;
        logic [15:0] prior_metric;
        logic [15:0] threshold;
        logic [7:0]  prior_best;
        logic [7:0]  prior_marker;
        logic [3:0]  slot_number;
    } ncs_op_t;

endpackage

>>> rtl/ncs_fifo.sv
// Small register-based first-in first-out queue.
module ncs_fifo #(
    parameter int  DEPTH  = 4,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    input  item_t wr_data,
    output logic  full,
    input  logic  rd_ready,
    output logic  rd_valid,
    output item_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_ready && rd_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/ncs_front.sv
// Front end: config registers, item intake and candidate classification.
module ncs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ncs_pkg::ncs_in_t in_item,
    output logic           full,
    input  logic           wr_en,
    input  logic           wr_index,
    input  logic [7:0]     wr_data,
    input  logic           q_full,
    output logic           q_push,
    output ncs_pkg::ncs_op_t q_data
);
    import ncs_pkg::*;

    localparam logic [8:0] CAND_LIMIT = 9'(CANDIDATES);

    logic [7:0] gate_mask_reg;
    logic [7:0] threshold_high_reg;
    logic [3:0] excluded_reg;
    logic       accept;
    logic       eligible;
    logic       is_start;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_start = (in_item.kind == KIND_START);

    // Candidate eligibility against the exclusion seen by this front end
    assign eligible = (in_item.item_index != excluded_reg)
                   && ((in_item.gate_bits & gate_mask_reg) != 8'd0)
                   && ({5'd0, in_item.item_index} < CAND_LIMIT);

    // Ineligible candidates that close no run do nothing downstream: drop them
    assign q_push = accept && (is_start || eligible || in_item.last);

    always_comb
    begin
        q_data              = '0;
        q_data.kind         = in_item.kind;
        q_data.eligible     = eligible;
        q_data.last         = in_item.last;
        q_data.pos_x        = in_item.pos_x;
        q_data.pos_depth    = in_item.pos_depth;
        q_data.item_index   = in_item.item_index;
        q_data.prior_metric = in_item.prior_metric;
        q_data.threshold    = {threshold_high_reg, in_item.prior_threshold_low};
        q_data.prior_best   = in_item.prior_best;
        q_data.prior_marker = in_item.prior_marker;
        q_data.slot_number  = in_item.slot_number;
    end

    // Config registers and the excluded index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mask_reg      <= GATE_MASK_RESET;
            threshold_high_reg <= THRESHOLD_HIGH_RESET;
            excluded_reg       <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_GATE_MASK:      gate_mask_reg      <= wr_data;
                    REG_THRESHOLD_HIGH: threshold_high_reg <= wr_data;
                    default:            gate_mask_reg      <= gate_mask_reg;
                endcase
            end
            if (accept && is_start)
            begin
                excluded_reg <= in_item.item_index;
            end
        end
    end

endmodule

>>> rtl/ncs_back.sv
// Back end: distance stage followed by the running-best update stage.
module ncs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ncs_pkg::ncs_op_t  q_data,
    output logic              q_pop,
    input  logic              res_full,
    output logic              res_push,
    output ncs_pkg::ncs_out_t res_data
);
    import ncs_pkg::*;

    logic [15:0] ref_x_reg;
    logic [7:0]  ref_depth_reg;
    logic        a_valid_reg;
    ncs_op_t     a_op_reg;
    logic [15:0] a_metric_reg;

    logic [15:0] run_last_metric_reg, run_last_metric_next;
    logic [15:0] run_best_metric_reg, run_best_metric_next;
    logic [7:0]  run_best_index_reg,  run_best_index_next;
    logic [7:0]  run_marker_reg,      run_marker_next;
    logic        run_improved_reg,    run_improved_next;
    logic [3:0]  run_slot_reg,        run_slot_next;

    logic [15:0] dx, dd, hi, lo, metric;
    logic        b_fire, a_ready, emits;

    // Distance: max(|dx|,|dd|) + min/2, wrapped to 16 bits
    always_comb
    begin
        dx = (q_data.pos_x >= ref_x_reg) ? q_data.pos_x - ref_x_reg
                                         : ref_x_reg - q_data.pos_x;
        dd = {8'd0, (q_data.pos_depth >= ref_depth_reg) ? q_data.pos_depth - ref_depth_reg
                                                        : ref_depth_reg - q_data.pos_depth};
        hi = (dx >= dd) ? dx : dd;
        lo = (dx >= dd) ? dd : dx;
        metric = hi + {1'b0, lo[15:1]};
    end

    // Handshake between the two stages
    assign emits   = (a_op_reg.kind == KIND_CAND) && a_op_reg.last;
    assign b_fire  = a_valid_reg && !(emits && res_full);
    assign a_ready = !a_valid_reg || b_fire;
    assign q_pop   = q_valid && a_ready;

    // Distance stage; a start updates the reference as it enters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            ref_x_reg     <= '0;
            ref_depth_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= q_valid;
            end
            if (q_pop && (q_data.kind == KIND_START))
            begin
                ref_x_reg     <= q_data.pos_x;
                ref_depth_reg <= q_data.pos_depth;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_op_reg     <= q_data;
            a_metric_reg <= metric;
        end
    end

    // Running best update
    always_comb
    begin
        run_last_metric_next = run_last_metric_reg;
        run_best_metric_next = run_best_metric_reg;
        run_best_index_next  = run_best_index_reg;
        run_marker_next      = run_marker_reg;
        run_improved_next    = run_improved_reg;
        run_slot_next        = run_slot_reg;
        if (a_op_reg.kind == KIND_START)
        begin
            run_last_metric_next = a_op_reg.prior_metric;
            run_best_metric_next = a_op_reg.threshold;
            run_best_index_next  = a_op_reg.prior_best;
            run_marker_next      = a_op_reg.prior_marker;
            run_improved_next    = 1'b0;
            run_slot_next        = a_op_reg.slot_number;
        end
        else if (a_op_reg.eligible)
        begin
            run_last_metric_next = a_metric_reg;
            if (a_metric_reg < run_best_metric_reg)
            begin
                run_best_metric_next = a_metric_reg;
                run_best_index_next  = {4'd0, a_op_reg.item_index};
                run_marker_next      = {4'd0, a_op_reg.item_index};
                run_improved_next    = 1'b1;
            end
        end
    end

    assign res_push = b_fire && emits;

    always_comb
    begin
        res_data.last_metric = run_last_metric_next;
        res_data.best_metric = run_best_metric_next;
        res_data.best_index  = run_best_index_next;
        res_data.best_marker = run_marker_next;
        res_data.improved    = run_improved_next;
        res_data.slot_out    = run_slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_last_metric_reg <= '0;
            run_best_metric_reg <= '0;
            run_best_index_reg  <= '0;
            run_marker_reg      <= '0;
            run_improved_reg    <= 1'b0;
            run_slot_reg        <= '0;
        end
        else if (b_fire)
        begin
            run_last_metric_reg <= run_last_metric_next;
            run_best_metric_reg <= run_best_metric_next;
            run_best_index_reg  <= run_best_index_next;
            run_marker_reg      <= run_marker_next;
            run_improved_reg    <= run_improved_next;
            run_slot_reg        <= run_slot_next;
        end
    end

endmodule

>>> rtl/nearest_candidate_scan.sv
// Nearest candidate scan: top level joining front end, op queue, back end and result queue.
// Throughput: one item per cycle, sustained, with results popped as they appear.
// Path to the output ports from the edge that accepts the closing candidate: op queue write,
// distance stage, running-best update into result queue.
// Reset: asynchronous, active low; queues empty, run state zero, gate mask 0x80,
// threshold high byte 0xFF. No clearing pass.
module nearest_candidate_scan #(
    parameter int QUEUE_DEPTH  = ncs_pkg::QUEUE_DEPTH,
    parameter int RESULT_DEPTH = ncs_pkg::RESULT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ncs_pkg::ncs_in_t  in_item,
    output logic              empty,
    input  logic              pop,
    output ncs_pkg::ncs_out_t out_item,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [7:0]        wr_data
);
    import ncs_pkg::*;

    logic     q_full, q_push, q_valid, q_pop;
    ncs_op_t  q_wdata, q_rdata;
    logic     res_full, res_push, res_valid;
    ncs_out_t res_data;

    ncs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // Op queue between front and back
    ncs_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (ncs_op_t)
    ) u_op_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_push),
        .wr_data  (q_wdata),
        .full     (q_full),
        .rd_ready (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    ncs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_data)
    );

    // Result queue towards the consumer
    ncs_fifo #(
        .DEPTH  (RESULT_DEPTH),
        .item_t (ncs_out_t)
    ) u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_push),
        .wr_data  (res_data),
        .full     (res_full),
        .rd_ready (pop),
        .rd_valid (res_valid),
        .rd_data  (out_item)
    );

    assign empty = !res_valid;

endmodule

>>> rtl/ncs_checker.sv
// Port-level checks for the nearest candidate scan, bound to the top level.
module ncs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input ncs_pkg::ncs_out_t out_item
);
    import ncs_pkg::*;

    // A waiting item stays put until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed or vanished");

    // An improvement always records a valid candidate index in both index fields
    a_improved_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.improved) |->
            (out_item.best_index == out_item.best_marker) && (out_item.best_index[7:4] == 4'd0))
        else $error("improved result with inconsistent index");

    // Out of reset both queues are empty
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind nearest_candidate_scan ncs_checker u_checker (.*);
